// ===== rtl/core/swfc16_pkg.sv =====
// Package for the sync-write frame builder: item structs, register indexes,
// controller states, byte selects and the command/status bundles.
// No dependencies.
`default_nettype none
package swfc16_pkg;

	typedef struct packed {
		logic [7:0]  device_id;
		logic [31:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
		logic       too_large;
	} out_item_t;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;
	localparam int SlotW = 4;

	localparam logic [CfgIdxW-1:0] CFG_START_ADDRESS = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_DATA_LENGTH   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_ENTRY_COUNT   = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_LENGTH_WORD   = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_BUFFER_LIMIT  = 3'd4;

	localparam logic [SlotW-1:0] HDR_LAST_SLOT = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_ID,
		ST_DATA,
		ST_CRC_LO,
		ST_CRC_HI,
		ST_ERR,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [2:0] {
		SEL_HDR,
		SEL_ID,
		SEL_DATA,
		SEL_CRC_LO,
		SEL_CRC_HI,
		SEL_ERR
	} byte_sel_t;

	typedef struct packed {
		logic             load;
		logic             emit;
		byte_sel_t        sel;
		logic [SlotW-1:0] slot;
		logic             step;
		logic             set_drop;
	} dp_cmd_t;

	typedef struct packed {
		logic       first;
		logic       last;
		logic       too_big;
		logic       dropping;
		logic       out_free;
		logic [2:0] dlen;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/swfc16_datapath.sv =====
// Datapath: configuration registers, entry latch, frame state, CRC-16 and
// the output register. Depends on swfc16_pkg.
`default_nettype none
module swfc16_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [swfc16_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire [swfc16_pkg::CfgDataW-1:0] cfg_data,
	input  swfc16_pkg::in_item_t         in_item,
	input  swfc16_pkg::dp_cmd_t          cmd,
	output swfc16_pkg::dp_status_t       stat,
	output logic                         out_valid,
	input  wire                          out_stall,
	output swfc16_pkg::out_item_t        out_item
);
	import swfc16_pkg::*;

	logic [15:0] start_address_q;
	logic [2:0]  data_length_q;
	logic [7:0]  entry_count_q;
	logic [15:0] length_word_q;
	logic [15:0] buffer_limit_q;

	logic [7:0]  entry_index_q;
	logic [15:0] crc_q;
	logic        dropping_q;
	logic [7:0]  id_q;
	logic [31:0] word_q;

	logic        out_valid_q;
	out_item_t   out_q;

	logic [2:0]  dlen;
	logic [7:0]  count;
	logic [10:0] need;
	logic [7:0]  hdr_byte;
	logic [7:0]  data_byte;
	out_item_t   emit_item;
	logic        feed;

	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ 16'h8005) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	assign dlen  = (data_length_q > 3'd4) ? 3'd4 : data_length_q;
	assign count = (entry_count_q == 8'd0) ? 8'd1 : entry_count_q;
	assign need  = 11'd14 + {3'b000, count} * ({8'h00, dlen} + 11'd1);

	assign stat.first    = (entry_index_q == 8'd0);
	assign stat.last     = ({1'b0, entry_index_q} + 9'd1) >= {1'b0, count};
	assign stat.too_big  = buffer_limit_q < {5'b00000, need};
	assign stat.dropping = dropping_q;
	assign stat.out_free = !out_valid_q || !out_stall;
	assign stat.dlen     = dlen;

	always_comb begin
		case (cmd.slot)
			4'd0:    hdr_byte = 8'hFF;
			4'd1:    hdr_byte = 8'hFF;
			4'd2:    hdr_byte = 8'hFD;
			4'd3:    hdr_byte = 8'h00;
			4'd4:    hdr_byte = 8'hFE;
			4'd5:    hdr_byte = length_word_q[7:0];
			4'd6:    hdr_byte = length_word_q[15:8];
			4'd7:    hdr_byte = 8'h83;
			4'd8:    hdr_byte = start_address_q[7:0];
			4'd9:    hdr_byte = start_address_q[15:8];
			4'd10:   hdr_byte = {5'b00000, dlen};
			default: hdr_byte = 8'h00;
		endcase
	end

	always_comb begin
		case (cmd.slot[1:0])
			2'd0:    data_byte = word_q[7:0];
			2'd1:    data_byte = word_q[15:8];
			2'd2:    data_byte = word_q[23:16];
			default: data_byte = word_q[31:24];
		endcase
	end

	always_comb begin
		emit_item = '0;
		feed = 1'b0;
		case (cmd.sel)
			SEL_HDR: begin
				emit_item.frame_byte = hdr_byte;
				feed = 1'b1;
			end
			SEL_ID: begin
				emit_item.frame_byte = id_q;
				feed = 1'b1;
			end
			SEL_DATA: begin
				emit_item.frame_byte = data_byte;
				feed = 1'b1;
			end
			SEL_CRC_LO: emit_item.frame_byte = crc_q[7:0];
			SEL_CRC_HI: begin
				emit_item.frame_byte = crc_q[15:8];
				emit_item.frame_end = 1'b1;
			end
			SEL_ERR: begin
				emit_item.frame_end = 1'b1;
				emit_item.too_large = 1'b1;
			end
			default: emit_item = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_address_q <= 16'd0;
			data_length_q   <= 3'd4;
			entry_count_q   <= 8'd1;
			length_word_q   <= 16'd7;
			buffer_limit_q  <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_ADDRESS: start_address_q <= cfg_data;
				CFG_DATA_LENGTH:   data_length_q   <= cfg_data[2:0];
				CFG_ENTRY_COUNT:   entry_count_q   <= cfg_data[7:0];
				CFG_LENGTH_WORD:   length_word_q   <= cfg_data;
				CFG_BUFFER_LIMIT:  buffer_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q   <= in_item.device_id;
			word_q <= in_item.data_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_index_q <= 8'd0;
			crc_q         <= 16'd0;
			dropping_q    <= 1'b0;
		end else begin
			if (cmd.load && stat.first) begin
				crc_q      <= 16'd0;
				dropping_q <= 1'b0;
			end else if (cmd.emit && feed) begin
				crc_q <= crc_next(crc_q, emit_item.frame_byte);
			end else if (cmd.step && stat.last) begin
				crc_q <= 16'd0;
			end
			if (cmd.set_drop) begin
				dropping_q <= 1'b1;
			end else if (cmd.step && stat.last) begin
				dropping_q <= 1'b0;
			end
			if (cmd.step) begin
				entry_index_q <= stat.last ? 8'd0 : entry_index_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.too_large |-> out_q.frame_end && out_q.frame_byte == 8'h00)
		else $error("error item without frame end");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && stat.last |=> entry_index_q == 8'd0 && crc_q == 16'd0 && !dropping_q)
		else $error("frame state not cleared after last entry");
	a_index_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && !stat.last |=> entry_index_q == 8'($past(entry_index_q) + 8'd1))
		else $error("entry index did not advance");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled output item overwritten");

endmodule
`default_nettype wire

// ===== rtl/core/swfc16_ctrl.sv =====
// Controller FSM: accepts an entry and sequences header, id, data, CRC
// and error bytes into the datapath. Depends on swfc16_pkg.
`default_nettype none
module swfc16_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  swfc16_pkg::dp_status_t stat,
	output swfc16_pkg::dp_cmd_t    cmd
);
	import swfc16_pkg::*;

	ctl_state_t       state_q, state_d;
	logic [SlotW-1:0] slot_q, slot_d;
	logic             data_end;

	assign data_end = (slot_q + 4'd1) == {1'b0, stat.dlen};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		slot_d       = slot_q;
		in_stall     = 1'b1;
		cmd          = '0;
		cmd.sel      = SEL_HDR;
		cmd.slot     = slot_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				slot_d   = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stat.first) begin
						state_d = stat.too_big ? ST_ERR : ST_HDR;
					end else begin
						state_d = stat.dropping ? ST_DONE : ST_ID;
					end
				end
			end
			ST_HDR: begin
				cmd.sel  = SEL_HDR;
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					if (slot_q == HDR_LAST_SLOT) begin
						slot_d  = '0;
						state_d = ST_ID;
					end else begin
						slot_d = slot_q + 4'd1;
					end
				end
			end
			ST_ID: begin
				cmd.sel  = SEL_ID;
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					slot_d = '0;
					if (stat.dlen != 3'd0) begin
						state_d = ST_DATA;
					end else begin
						state_d = stat.last ? ST_CRC_LO : ST_DONE;
					end
				end
			end
			ST_DATA: begin
				cmd.sel  = SEL_DATA;
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					if (data_end) begin
						slot_d  = '0;
						state_d = stat.last ? ST_CRC_LO : ST_DONE;
					end else begin
						slot_d = slot_q + 4'd1;
					end
				end
			end
			ST_CRC_LO: begin
				cmd.sel  = SEL_CRC_LO;
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					state_d = ST_CRC_HI;
				end
			end
			ST_CRC_HI: begin
				cmd.sel  = SEL_CRC_HI;
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					state_d = ST_DONE;
				end
			end
			ST_ERR: begin
				cmd.sel  = SEL_ERR;
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					cmd.set_drop = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.step = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q != ST_IDLE && state_q != ST_CRC_LO && state_q != ST_CRC_HI)
		else $error("entry load did not start a sequence");
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> state_q == ST_IDLE)
		else $error("entry step not followed by idle");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.out_free |-> !cmd.emit ##1 $stable(slot_q))
		else $error("byte emitted into a full output register");

endmodule
`default_nettype wire

// ===== rtl/core/sync_write_frame_crc16_core.sv =====
// Top level of the sync-write frame builder with CRC-16 (0x8005, init 0).
// Instantiates swfc16_ctrl and swfc16_datapath; depends on swfc16_pkg.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_item (device_id, data_word)
//   out     | output    | out_valid/out_stall | out_item (frame_byte, frame_end, too_large)
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// Within a byte sequence, one output byte per cycle while out is not stalled; an entry
// is accepted, gives its id byte and data_length (capped at 4) data bytes, then steps,
// with the 12 header bytes first on the first entry and the 2 CRC bytes last on the
// last; an error entry gives one error item, a dropped entry none. The byte sequencer in
// swfc16_ctrl sets this order. arst_n clears the controller, frame state and output
// valid; config is reset too. A full stalled output holds the byte-emitting states.
`default_nettype none
module sync_write_frame_crc16_core (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  swfc16_pkg::in_item_t           in_item,
	output logic                           out_valid,
	input  wire                            out_stall,
	output swfc16_pkg::out_item_t          out_item,
	input  wire                            cfg_we,
	input  wire [swfc16_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire [swfc16_pkg::CfgDataW-1:0] cfg_data
);
	import swfc16_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t stat;

	swfc16_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	swfc16_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire
